### src/bnn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnn_pkg
// Shared types and constants of the batched nearest neighbour unit.
// ----------------------------------------------------------------------------
package bnn_pkg;

  localparam int MAX_REFS_DEF   = 1024;
  localparam int COORD_BITS_DEF = 16;

  localparam int NUM_LANES  = 4;
  localparam int LANE_BITS  = 2;
  localparam int DRAIN_LAST = 2;   // edges after the last row issue, minus one

  localparam int OPC_W    = 2;
  localparam int COORD_W  = 16;
  localparam int BATCH_W  = 8;
  localparam int STATUS_W = 3;
  localparam int OIDX_W   = 10;
  localparam int ODIST_W  = 34;

  localparam logic [OPC_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OPC_W-1:0] OP_QUERY = 2'd1;
  localparam logic [OPC_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] ST_LOADED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MATCH   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOMATCH = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_MERGE,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic wr_en;
    logic issue;
    logic start;
  } lane_cmd_t;

endpackage

### src/batched_nearest_neighbour_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// batched_nearest_neighbour_unit
// Reference store with batched brute-force nearest neighbour search.
// ----------------------------------------------------------------------------
// The result of a load, clear or unused opcode goes through the EMIT state into
// the output register once the item is taken. A query reads four store entries
// per cycle, one per lane bank; its result goes through the scan, the drain of
// the lane pipelines, the lane-by-lane merge and the EMIT state into the output
// register, and the EMIT state waits while a held result is stalled.
// The scan is set by the single read port of each lane bank. One item is in
// work at a time; a new item is taken while the previous result waits.
// ----------------------------------------------------------------------------
module batched_nearest_neighbour_unit #(
  parameter int MAX_REFS   = bnn_pkg::MAX_REFS_DEF,
  parameter int COORD_BITS = bnn_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bnn_pkg::OPC_W-1:0]           in_opcode,
  input  logic signed [bnn_pkg::COORD_W-1:0]  in_coord_a,
  input  logic signed [bnn_pkg::COORD_W-1:0]  in_coord_b,
  input  logic signed [bnn_pkg::COORD_W-1:0]  in_coord_c,
  input  logic [bnn_pkg::BATCH_W-1:0]         in_batch_id,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bnn_pkg::STATUS_W-1:0]        out_status,
  output logic [bnn_pkg::OIDX_W-1:0]          out_nearest_index,
  output logic [bnn_pkg::ODIST_W-1:0]         out_min_distance
);

  localparam int L      = bnn_pkg::NUM_LANES;
  localparam int LB     = bnn_pkg::LANE_BITS;
  localparam int CB     = COORD_BITS;
  localparam int DEPTH  = (MAX_REFS + L - 1) / L;
  localparam int ROW_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W  = ROW_W + LB;
  localparam int CNT_W  = $clog2(MAX_REFS + 1);
  localparam int DW     = 2 * CB + 4;

  bnn_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [1:0]        drain_r, drain_nxt;
  logic [CB-1:0]     q_a_r, q_b_r, q_c_r;
  logic [bnn_pkg::BATCH_W-1:0] q_batch_r;
  logic [bnn_pkg::STATUS_W-1:0] res_status_r;
  logic [IDX_W-1:0]  res_idx_r;
  logic [DW-1:0]     res_dist_r;
  logic              out_valid_r;
  logic [bnn_pkg::STATUS_W-1:0] out_status_r;
  logic [bnn_pkg::OIDX_W-1:0]   out_idx_r;
  logic [bnn_pkg::ODIST_W-1:0]  out_dist_r;

  logic              accept, issue, lanes_start, merge_start, out_load, last_row;
  logic [CB-1:0]     in_a, in_b, in_c;
  logic [IDX_W-1:0]  widx;
  logic              room;

  logic [L-1:0]      lane_found;
  logic [DW-1:0]     lane_dist [L];
  logic [ROW_W-1:0]  lane_row  [L];
  logic              m_done, m_found;
  logic [DW-1:0]     m_dist;
  logic [IDX_W-1:0]  m_idx;
  logic [63:0]       dist_wide;
  logic [31:0]       idx_wide;

  assign in_a   = CB'($unsigned(in_coord_a));
  assign in_b   = CB'($unsigned(in_coord_b));
  assign in_c   = CB'($unsigned(in_coord_c));
  assign accept = in_valid && !in_stall;
  assign room   = 32'(count_r) < 32'(MAX_REFS);
  assign widx   = IDX_W'(count_r);
  assign last_row = (32'({row_r, LB'(0)}) + 32'(L) >= 32'(count_r))
                    || (row_r == ROW_W'(DEPTH - 1));

  for (genvar g = 0; g < L; g++) begin : g_lane
    bnn_pkg::lane_cmd_t cmd;
    logic               rd_ok;

    assign cmd.wr_en = accept && in_opcode == bnn_pkg::OP_LOAD && room
                       && widx[LB-1:0] == LB'(g);
    assign cmd.issue = issue;
    assign cmd.start = lanes_start;
    assign rd_ok     = 32'({row_r, LB'(g)}) < 32'(count_r);

    bnn_lane #(
      .CB    (CB),
      .DEPTH (DEPTH),
      .ROW_W (ROW_W),
      .DW    (DW)
    ) u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .wr_row    (widx[IDX_W-1:LB]),
      .wr_a      (in_a),
      .wr_b      (in_b),
      .wr_c      (in_c),
      .wr_batch  (in_batch_id),
      .rd_row    (row_r),
      .rd_ok     (rd_ok),
      .q_a       (q_a_r),
      .q_b       (q_b_r),
      .q_c       (q_c_r),
      .q_batch   (q_batch_r),
      .found     (lane_found[g]),
      .best_dist (lane_dist[g]),
      .best_row  (lane_row[g])
    );
  end

  bnn_merge #(
    .DW    (DW),
    .ROW_W (ROW_W),
    .IDX_W (IDX_W)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (merge_start),
    .lane_found (lane_found),
    .lane_dist  (lane_dist),
    .lane_row   (lane_row),
    .done       (m_done),
    .found      (m_found),
    .min_dist   (m_dist),
    .idx        (m_idx)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    row_nxt   = row_r;
    drain_nxt = drain_r;
    case (state_r)
      bnn_pkg::S_IDLE: begin
        if (accept) begin
          row_nxt = '0;
          if (in_opcode == bnn_pkg::OP_QUERY) begin
            state_nxt = bnn_pkg::S_SCAN;
          end else begin
            state_nxt = bnn_pkg::S_EMIT;
          end
          if (in_opcode == bnn_pkg::OP_LOAD && room) begin
            count_nxt = count_r + 1'b1;
          end else if (in_opcode == bnn_pkg::OP_CLEAR) begin
            count_nxt = '0;
          end
        end
      end
      bnn_pkg::S_SCAN: begin
        if (last_row) begin
          state_nxt = bnn_pkg::S_DRAIN;
          drain_nxt = '0;
        end else begin
          row_nxt = row_r + 1'b1;
        end
      end
      bnn_pkg::S_DRAIN: begin
        drain_nxt = drain_r + 1'b1;
        if (drain_r == 2'(bnn_pkg::DRAIN_LAST)) begin
          state_nxt = bnn_pkg::S_MERGE;
        end
      end
      bnn_pkg::S_MERGE: begin
        if (m_done) begin
          state_nxt = bnn_pkg::S_EMIT;
        end
      end
      bnn_pkg::S_EMIT: begin
        if (out_load) begin
          state_nxt = bnn_pkg::S_IDLE;
        end
      end
      default: state_nxt = bnn_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall    = 1'b1;
    issue       = 1'b0;
    lanes_start = 1'b0;
    merge_start = 1'b0;
    out_load    = 1'b0;
    case (state_r)
      bnn_pkg::S_IDLE: begin
        in_stall    = 1'b0;
        lanes_start = accept;
      end
      bnn_pkg::S_SCAN:  issue = 1'b1;
      bnn_pkg::S_DRAIN: merge_start = (drain_r == 2'(bnn_pkg::DRAIN_LAST));
      bnn_pkg::S_MERGE: ;
      bnn_pkg::S_EMIT:  out_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bnn_pkg::S_IDLE;
      count_r     <= '0;
      row_r       <= '0;
      drain_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      row_r   <= row_nxt;
      drain_r <= drain_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign dist_wide = 64'(res_dist_r);
  assign idx_wide  = 32'(res_idx_r);

  always_ff @(posedge clk) begin
    if (accept) begin
      q_a_r     <= in_a;
      q_b_r     <= in_b;
      q_c_r     <= in_c;
      q_batch_r <= in_batch_id;
      res_idx_r  <= '0;
      res_dist_r <= '0;
      case (in_opcode)
        bnn_pkg::OP_LOAD:  res_status_r <= room ? bnn_pkg::ST_LOADED : bnn_pkg::ST_FULL;
        bnn_pkg::OP_CLEAR: res_status_r <= bnn_pkg::ST_CLEARED;
        default:           res_status_r <= bnn_pkg::ST_NOMATCH;
      endcase
    end else if (state_r == bnn_pkg::S_MERGE && m_done) begin
      res_status_r <= m_found ? bnn_pkg::ST_MATCH : bnn_pkg::ST_NOMATCH;
      res_idx_r    <= m_found ? m_idx : '0;
      res_dist_r   <= m_found ? m_dist : '0;
    end
    if (out_load) begin
      out_status_r <= res_status_r;
      out_idx_r    <= idx_wide[bnn_pkg::OIDX_W-1:0];
      out_dist_r   <= dist_wide[bnn_pkg::ODIST_W-1:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_nearest_index = out_idx_r;
  assign out_min_distance  = out_dist_r;

endmodule

### src/bnn_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnn_lane
// One search lane: a bank of the reference store and a distance pipeline
// that keeps the nearest same-batch entry seen in this bank.
// ----------------------------------------------------------------------------
module bnn_lane #(
  parameter int CB    = bnn_pkg::COORD_BITS_DEF,
  parameter int DEPTH = 256,
  parameter int ROW_W = 8,
  parameter int DW    = 2 * CB + 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bnn_pkg::lane_cmd_t          cmd,
  input  logic [ROW_W-1:0]            wr_row,
  input  logic [CB-1:0]               wr_a,
  input  logic [CB-1:0]               wr_b,
  input  logic [CB-1:0]               wr_c,
  input  logic [bnn_pkg::BATCH_W-1:0] wr_batch,
  input  logic [ROW_W-1:0]            rd_row,
  input  logic                        rd_ok,
  input  logic [CB-1:0]               q_a,
  input  logic [CB-1:0]               q_b,
  input  logic [CB-1:0]               q_c,
  input  logic [bnn_pkg::BATCH_W-1:0] q_batch,
  output logic                        found,
  output logic [DW-1:0]               best_dist,
  output logic [ROW_W-1:0]            best_row
);

  localparam int WW = 3 * CB + bnn_pkg::BATCH_W;
  localparam int SW = 2 * CB + 2;

  logic [WW-1:0] mem [DEPTH];
  logic [WW-1:0] rd_data_r;
  logic          v1_r, v2_r, v3_r;
  logic [ROW_W-1:0] row1_r, row2_r, row3_r;
  logic [SW-1:0] sq_a_r, sq_b_r, sq_c_r;
  logic [DW-1:0] sum_r;
  logic          found_r;
  logic [DW-1:0] best_r;
  logic [ROW_W-1:0] brow_r;

  logic signed [CB:0]   d_a, d_b, d_c;
  logic signed [SW-1:0] p_a, p_b, p_c;
  logic                 hit;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_row] <= {wr_batch, wr_c, wr_b, wr_a};
    end
    rd_data_r <= mem[rd_row];
  end

  always_comb begin
    d_a = $signed({q_a[CB-1], q_a}) - $signed({rd_data_r[CB-1], rd_data_r[CB-1:0]});
    d_b = $signed({q_b[CB-1], q_b})
        - $signed({rd_data_r[2*CB-1], rd_data_r[2*CB-1:CB]});
    d_c = $signed({q_c[CB-1], q_c})
        - $signed({rd_data_r[3*CB-1], rd_data_r[3*CB-1:2*CB]});
    p_a = d_a * d_a;
    p_b = d_b * d_b;
    p_c = d_c * d_c;
    hit = v1_r && (rd_data_r[WW-1:3*CB] == q_batch);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      found_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue && rd_ok;
      v2_r <= hit;
      v3_r <= v2_r;
      if (cmd.start) begin
        found_r <= 1'b0;
      end else if (v3_r && (!found_r || sum_r < best_r)) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    row1_r <= rd_row;
    row2_r <= row1_r;
    row3_r <= row2_r;
    sq_a_r <= $unsigned(p_a);
    sq_b_r <= $unsigned(p_b);
    sq_c_r <= $unsigned(p_c);
    sum_r  <= DW'(sq_a_r) + DW'(sq_b_r) + DW'(sq_c_r);
    // strict compare keeps the lowest row on ties
    if (v3_r && (!found_r || sum_r < best_r) && !cmd.start) begin
      best_r <= sum_r;
      brow_r <= row3_r;
    end
  end

  assign found     = found_r;
  assign best_dist = best_r;
  assign best_row  = brow_r;

endmodule

### src/bnn_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnn_merge
// Walks the lane results one per cycle and keeps the overall nearest entry,
// lowest store index on equal distance.
// ----------------------------------------------------------------------------
module bnn_merge #(
  parameter int DW    = 36,
  parameter int ROW_W = 8,
  parameter int IDX_W = ROW_W + bnn_pkg::LANE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [bnn_pkg::NUM_LANES-1:0] lane_found,
  input  logic [DW-1:0]         lane_dist [bnn_pkg::NUM_LANES],
  input  logic [ROW_W-1:0]      lane_row  [bnn_pkg::NUM_LANES],
  output logic                  done,
  output logic                  found,
  output logic [DW-1:0]         min_dist,
  output logic [IDX_W-1:0]      idx
);

  logic                           busy_r, done_r, found_r;
  logic [bnn_pkg::LANE_BITS-1:0]  lane_r;
  logic [DW-1:0]                  dist_r;
  logic [IDX_W-1:0]               idx_r;
  logic [DW-1:0]                  c_dist;
  logic [IDX_W-1:0]               c_idx;
  logic                           take;

  always_comb begin
    c_dist = lane_dist[lane_r];
    c_idx  = {lane_row[lane_r], lane_r};
    take   = busy_r && lane_found[lane_r]
             && (!found_r || c_dist < dist_r || (c_dist == dist_r && c_idx < idx_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      found_r <= 1'b0;
      lane_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        found_r <= 1'b0;
        lane_r  <= '0;
      end else if (busy_r) begin
        if (take) begin
          found_r <= 1'b1;
        end
        lane_r <= lane_r + 1'b1;
        if (lane_r == bnn_pkg::LANE_BITS'(bnn_pkg::NUM_LANES - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      dist_r <= c_dist;
      idx_r  <= c_idx;
    end
  end

  assign done     = done_r;
  assign found    = found_r;
  assign min_dist = dist_r;
  assign idx      = idx_r;

endmodule

### src/bnn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnn_checker
// Port-level checks of the nearest neighbour unit, bound to the top level.
// ----------------------------------------------------------------------------
module bnn_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [bnn_pkg::STATUS_W-1:0] out_status,
  input logic [bnn_pkg::OIDX_W-1:0]   out_nearest_index,
  input logic [bnn_pkg::ODIST_W-1:0]  out_min_distance
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_nearest_index) && $stable(out_min_distance))
    else $error("result item changed while stalled");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == bnn_pkg::ST_LOADED || out_status == bnn_pkg::ST_FULL
      || out_status == bnn_pkg::ST_CLEARED || out_status == bnn_pkg::ST_MATCH
      || out_status == bnn_pkg::ST_NOMATCH))
    else $error("illegal status code");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != bnn_pkg::ST_MATCH
      |-> out_nearest_index == '0 && out_min_distance == '0)
    else $error("index or distance set without a match");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item taken while previous item still in work");

endmodule

bind batched_nearest_neighbour_unit bnn_checker u_bnn_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_nearest_index (out_nearest_index),
  .out_min_distance  (out_min_distance)
);

### sim/batched_nearest_neighbour_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// batched_nearest_neighbour_unit_tb
// Loads reference points, runs queries and clears through the item channel,
// predicts every result with a behavioural copy of the reference store and
// checks status, index and distance of each result in order.
// ----------------------------------------------------------------------------
module batched_nearest_neighbour_unit_tb;

  localparam int NREFS    = bnn_pkg::MAX_REFS_DEF;
  localparam int WD_LIMIT = 20000;
  localparam int N_RANDOM = 520;
  localparam logic [bnn_pkg::OPC_W-1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [bnn_pkg::OPC_W-1:0]          opcode;
    logic signed [bnn_pkg::COORD_W-1:0] ca;
    logic signed [bnn_pkg::COORD_W-1:0] cb;
    logic signed [bnn_pkg::COORD_W-1:0] cc;
    logic [bnn_pkg::BATCH_W-1:0]        bid;
  } point_item_t;

  typedef struct packed {
    logic [bnn_pkg::STATUS_W-1:0] status;
    logic [bnn_pkg::OIDX_W-1:0]   idx;
    logic [bnn_pkg::ODIST_W-1:0]  distance;
  } search_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [bnn_pkg::OPC_W-1:0] in_opcode = '0;
  logic signed [bnn_pkg::COORD_W-1:0] in_coord_a = '0, in_coord_b = '0, in_coord_c = '0;
  logic [bnn_pkg::BATCH_W-1:0] in_batch_id = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [bnn_pkg::STATUS_W-1:0] out_status;
  logic [bnn_pkg::OIDX_W-1:0] out_nearest_index;
  logic [bnn_pkg::ODIST_W-1:0] out_min_distance;

  always #2 clk = ~clk;

  batched_nearest_neighbour_unit i_dut (.*);

  point_item_t    pending_items[$];
  search_result_t expected_results[$];

  // shadow store
  logic signed [bnn_pkg::COORD_W-1:0] store_a[NREFS], store_b[NREFS], store_c[NREFS];
  logic [bnn_pkg::BATCH_W-1:0] store_bid[NREFS];
  int store_count = 0;

  int  failures = 0;
  int  idle_cycles = 0;
  bit  hold_receiver = 1'b0;
  bit  hold_sender = 1'b0;

  function automatic search_result_t predict_search(point_item_t it);
    search_result_t r;
    logic [bnn_pkg::ODIST_W:0] d;
    logic signed [bnn_pkg::COORD_W:0] da, db, dc;
    bit found;
    found = 1'b0;
    r = '{status: bnn_pkg::ST_NOMATCH, idx: '0, distance: '0};
    case (it.opcode)
      bnn_pkg::OP_LOAD: begin
        if (store_count >= NREFS) begin
          r.status = bnn_pkg::ST_FULL;
        end else begin
          store_a[store_count] = it.ca;
          store_b[store_count] = it.cb;
          store_c[store_count] = it.cc;
          store_bid[store_count] = it.bid;
          store_count++;
          r.status = bnn_pkg::ST_LOADED;
        end
      end
      bnn_pkg::OP_QUERY: begin
        for (int i = 0; i < store_count; i++) begin
          if (store_bid[i] == it.bid) begin
            da = it.ca - store_a[i];
            db = it.cb - store_b[i];
            dc = it.cc - store_c[i];
            d = bnn_pkg::ODIST_W'(da * da) + bnn_pkg::ODIST_W'(db * db)
                + bnn_pkg::ODIST_W'(dc * dc);
            if (!found || d < r.distance) begin
              found = 1'b1;
              r.distance = d[bnn_pkg::ODIST_W-1:0];
              r.idx = bnn_pkg::OIDX_W'(i);
            end
          end
        end
        if (found) r.status = bnn_pkg::ST_MATCH;
      end
      bnn_pkg::OP_CLEAR: begin
        store_count = 0;
        r.status = bnn_pkg::ST_CLEARED;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic signed [bnn_pkg::COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return bnn_pkg::COORD_W'($urandom_range(0, 15)) - 16'sd8;
      default: return bnn_pkg::COORD_W'($urandom);
    endcase
  endfunction

  function automatic point_item_t make_item(logic [bnn_pkg::OPC_W-1:0] op,
                                            logic [bnn_pkg::BATCH_W-1:0] b);
    point_item_t it;
    it.opcode = op;
    it.ca = rand_coord();
    it.cb = rand_coord();
    it.cc = ($urandom_range(0, 3) == 0) ? '0 : rand_coord();
    it.bid = b;
    return it;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_search_push(.it({in_opcode, in_coord_a, in_coord_b, in_coord_c,
                                 in_batch_id}));
        void'(pending_items.pop_front());
        send_gap = gap_len();
      end
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0 || hold_sender || pending_items.size() == 0) begin
          if (send_gap > 0) send_gap--;
          in_valid <= 1'b0;
        end else begin
          in_valid    <= 1'b1;
          in_opcode   <= pending_items[0].opcode;
          in_coord_a  <= pending_items[0].ca;
          in_coord_b  <= pending_items[0].cb;
          in_coord_c  <= pending_items[0].cc;
          in_batch_id <= pending_items[0].bid;
        end
      end
    end
  end

  task automatic predict_search_push(point_item_t it);
    expected_results.push_back(predict_search(it));
  endtask

  // monitor and receiver stall
  int recv_gap = 0;
  search_result_t want;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result status=%0d idx=%0d dist=%0d", $time,
                   out_status, out_nearest_index, out_min_distance);
          failures++;
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status || out_nearest_index !== want.idx ||
              out_min_distance !== want.distance) begin
            $display("%0t: expected status=%0d idx=%0d dist=%0d, got %0d %0d %0d",
                     $time, want.status, want.idx, want.distance, out_status,
                     out_nearest_index, out_min_distance);
            failures++;
          end
        end
      end
      if (recv_gap == 0) recv_gap = gap_len();
      else recv_gap--;
      out_stall <= hold_receiver || (recv_gap > 0 && $urandom_range(0, 1) == 1);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WD_LIMIT) begin
        $display("batched_nearest_neighbour_unit: mismatch");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_results.size() != 0 || in_valid)
      @(posedge clk);
  endtask

  initial begin
    logic [bnn_pkg::BATCH_W-1:0] b;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty store query, extremes, every opcode, unused opcode
    pending_items.push_back(make_item(bnn_pkg::OP_QUERY, 8'd0));
    pending_items.push_back('{bnn_pkg::OP_LOAD, 16'sh7fff, 16'sh7fff, 16'sh7fff, 8'hff});
    pending_items.push_back('{bnn_pkg::OP_LOAD, 16'sh8000, 16'sh8000, 16'sh8000, 8'hff});
    pending_items.push_back('{bnn_pkg::OP_LOAD, 16'sh8000, 16'sh8000, 16'sh8000, 8'hff});
    pending_items.push_back('{bnn_pkg::OP_QUERY, 16'sh7fff, 16'sh7fff, 16'sh7fff, 8'hff});
    pending_items.push_back('{bnn_pkg::OP_QUERY, 16'sh8000, 16'sh8000, 16'sh8000, 8'hff});
    pending_items.push_back('{bnn_pkg::OP_QUERY, 16'sh0000, 16'sh0000, 16'sh0000, 8'hff});
    pending_items.push_back('{bnn_pkg::OP_QUERY, 16'sh0000, 16'sh0000, 16'sh0000, 8'h00});
    pending_items.push_back('{bnn_pkg::OP_LOAD, 16'sh0000, 16'sh0000, 16'sh0000, 8'h00});
    pending_items.push_back('{bnn_pkg::OP_QUERY, 16'sh7fff, 16'sh8000, 16'sh7fff, 8'h00});
    pending_items.push_back('{OP_SPARE, 16'sh1234, 16'sh5678, 16'sh0abc, 8'h00});
    pending_items.push_back('{bnn_pkg::OP_CLEAR, 16'sh0000, 16'sh0000, 16'sh0000, 8'h00});
    pending_items.push_back('{bnn_pkg::OP_QUERY, 16'sh0000, 16'sh0000, 16'sh0000, 8'hff});
    wait_drained();

    // hold the receiver off while loads keep coming, so the input stalls
    hold_receiver = 1'b1;
    for (int i = 0; i < 40; i++)
      pending_items.push_back(make_item(bnn_pkg::OP_LOAD, 8'($urandom_range(0, 3))));
    repeat (300) @(posedge clk);
    hold_receiver = 1'b0;
    for (int i = 0; i < 6; i++)
      pending_items.push_back(make_item(bnn_pkg::OP_QUERY, 8'(i)));
    wait_drained();

    // sender holds a queued clear back, then lets it go
    hold_sender = 1'b1;
    pending_items.push_back(make_item(bnn_pkg::OP_CLEAR, 8'd0));
    repeat (20) @(posedge clk);
    hold_sender = 1'b0;
    wait_drained();

    // random mix: small stores, loads and queries on few batches, rare clears and spares
    for (int k = 0; k < N_RANDOM; k++) begin
      case ($urandom_range(0, 19))
        0:       pending_items.push_back(make_item(bnn_pkg::OP_CLEAR, 8'($urandom)));
        1:       pending_items.push_back(make_item(OP_SPARE, 8'($urandom)));
        2, 3, 4, 5, 6, 7, 8, 9:
                 pending_items.push_back(make_item(bnn_pkg::OP_LOAD,
                   ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3))));
        default: begin
          b = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
          pending_items.push_back(make_item(bnn_pkg::OP_QUERY, b));
        end
      endcase
    end
    wait_drained();
    repeat (300) @(posedge clk);

    if (failures == 0 && expected_results.size() == 0)
      $display("batched_nearest_neighbour_unit: match");
    else
      $display("batched_nearest_neighbour_unit: mismatch");
    $finish;
  end

endmodule
